// ===== hdl/sks_pkg.sv =====
// Package with shared types and constants of the sorted key set.
`timescale 1ns / 1ps
package sks_pkg;
   localparam int CAPACITY = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FIFO_DEPTH = 2;
   localparam logic signed [31:0] RESERVED_KEY = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_FIND   = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_RESERVED = 3'd4
   } status_type;

   // States of the back end: waiting for a request, or carrying one out.
   typedef enum logic [0:0] { B_IDLE, B_EXEC } bstate_type;

   // Classified request passed from the front to the back.
   typedef struct packed {
      func_type           func;
      logic signed [31:0] key;
      logic               reserved;
   } cmd_type;
endpackage

// ===== hdl/sks_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface sks_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] key;
   modport source (output valid, func, key, input ready);
   modport sink (input valid, func, key, output ready);
endinterface

interface sks_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] entry_count;
   modport source (output valid, status, entry_count, input ready);
   modport sink (input valid, status, entry_count, output ready);
endinterface

// ===== hdl/sorted_key_set.sv =====
// Requests enter a two-entry queue that accepts them while the back end works or stalls,
// until it is full. When idle, the back end takes the head and every cell compares it;
// the comparison is registered, and in the execute state the cells shift and the response
// is registered at rsp. A new request is taken only when idle and no response is stalled.
// Reset is synchronous and active high; it empties the set and the queue.
`timescale 1ns / 1ps
module sorted_key_set (
   input  logic       clock,
   input  logic       reset,
   sks_req_if.sink    req,
   sks_rsp_if.source  rsp
);
   import sks_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   // The front end classifies each request and queues it.
   sks_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   // The back end holds the keys in a row of sorted cells and answers.
   sks_back u_back (
      .clock(clock), .reset(reset), .cmd(cmd),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .rsp(rsp)
   );
endmodule

// ===== hdl/sks_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module sks_front (
   input  logic                 clock,
   input  logic                 reset,
   sks_req_if.sink              req,
   output sks_pkg::cmd_type     cmd,
   output logic                 cmd_valid,
   input  logic                 cmd_take
);
   import sks_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   cmd_type           q_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]    cnt_ff, cnt_in;
   logic              push;
   cmd_type           entry;

   assign req.ready = (cnt_ff != (PTR_W+1)'(FIFO_DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      entry.func     = func_type'(req.func);
      entry.key      = req.key;
      entry.reserved = (req.key == RESERVED_KEY);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = cmd_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= entry;
   end
endmodule

// ===== hdl/sks_back.sv =====
// Back end: row of compare-and-shift cells that holds the ordered keys.
`timescale 1ns / 1ps
module sks_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sks_pkg::cmd_type     cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_take,
   sks_rsp_if.source            rsp
);
   import sks_pkg::*;

   bstate_type         st_ff, st_in;
   logic signed [31:0] keys_ff [CAPACITY];
   logic signed [31:0] keys_in [CAPACITY];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CAPACITY-1:0] lt_ff, lt_in, eq_ff, eq_in;
   logic               ov_ff, ov_in;
   logic [2:0]         ost_ff, ost_in;
   logic [4:0]         ocnt_ff, ocnt_in;
   logic               present;
   logic               full;

   // Compare step: every cell compares its key with the request key.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (CNT_W'(i) < cnt_ff) && (keys_ff[i] < cmd.key);
         eq_in[i] = (CNT_W'(i) < cnt_ff) && (keys_ff[i] == cmd.key);
      end
   end

   assign present = |eq_ff;
   assign full    = (cnt_ff >= CNT_W'(CAPACITY));
   assign cmd_take = (st_ff == B_IDLE) && cmd_valid && (!ov_ff || rsp.ready);
   assign rsp.valid       = ov_ff;
   assign rsp.status      = ost_ff;
   assign rsp.entry_count = ocnt_ff;

   // Execute step: each cell shifts or loads from its own and its neighbour's comparison bits.
   always_comb begin
      st_in   = st_ff;
      cmd_in  = cmd_ff;
      cnt_in  = cnt_ff;
      ost_in  = ost_ff;
      ocnt_in = ocnt_ff;
      ov_in   = ov_ff && !rsp.ready;
      for (int i = 0; i < CAPACITY; i++) keys_in[i] = keys_ff[i];
      unique case (st_ff)
         B_IDLE: begin
            if (cmd_take) begin
               cmd_in = cmd;
               st_in  = B_EXEC;
            end
         end
         B_EXEC: begin
            st_in  = B_IDLE;
            ov_in  = 1'b1;
            ost_in = ST_NOTFOUND;
            unique case (cmd_ff.func)
               FUNC_INSERT: begin
                  if (cmd_ff.reserved || present) ost_in = ST_DUP;
                  else if (full) ost_in = ST_FULL;
                  else begin
                     ost_in = ST_OK;
                     cnt_in = cnt_ff + CNT_W'(1);
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (!lt_ff[i]) begin
                           if (i == 0 || lt_ff[(i == 0) ? 0 : i-1]) keys_in[i] = cmd_ff.key;
                           else keys_in[i] = keys_ff[(i == 0) ? 0 : i-1];
                        end
                     end
                  end
               end
               FUNC_FIND: ost_in = (cmd_ff.reserved || present) ? ST_OK : ST_NOTFOUND;
               FUNC_REMOVE: begin
                  if (cmd_ff.reserved) ost_in = ST_RESERVED;
                  else if (present) begin
                     ost_in = ST_OK;
                     cnt_in = cnt_ff - CNT_W'(1);
                     for (int i = 0; i < CAPACITY - 1; i++)
                        if (!lt_ff[i]) keys_in[i] = keys_ff[i+1];
                  end
               end
               FUNC_NONE: ost_in = ST_NOTFOUND;
               default: ost_in = ST_NOTFOUND;
            endcase
            ocnt_in = 5'(cnt_in);
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_IDLE;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
      cmd_ff  <= cmd_in;
      lt_ff   <= (st_ff == B_IDLE) ? lt_in : lt_ff;
      eq_ff   <= (st_ff == B_IDLE) ? eq_in : eq_ff;
      ost_ff  <= ost_in;
      ocnt_ff <= ocnt_in;
      for (int i = 0; i < CAPACITY; i++) keys_ff[i] <= keys_in[i];
   end
endmodule

// ===== hdl/sks_checker.sv =====
// Port-level checker for the sorted key set and its bind.
`timescale 1ns / 1ps
module sks_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_entry_count
);
   import sks_pkg::*;

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_RESERVED) else $error("bad status");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 5'(CAPACITY)) else $error("count too big");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_entry_count == 5'(CAPACITY))
      else $error("full with room");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_noresp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready) else $error("not idle after reset");
endmodule

bind sorted_key_set sks_checker u_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_entry_count(rsp.entry_count)
);

// ===== bench/tb_sorted_key_set.sv =====
// Testbench for the sorted key set: directed and random requests checked against a model.
`timescale 1ns / 1ps
module tb_sorted_key_set;
   import sks_pkg::*;

   // Clock and the single reset pulse at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sks_req_if req_ch ();
   sks_rsp_if rsp_ch ();

   sorted_key_set dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // One expected response: the status and the entry count after the request.
   typedef struct {
      status_type status;
      logic [4:0] entry_count;
   } expected_rsp_type;

   // Our own copy of the set, kept in ascending order, and the expected responses.
   logic signed [31:0] model_keys[$];
   expected_rsp_type   pending_rsp[$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet_tail = 1'b0;
   bit  sender_busy = 1'b0;
   int  sink_stall = 0;

   localparam int CYCLE_LIMIT = 400000;

   // Predict the response of one request and update the model set.
   function automatic expected_rsp_type predict_set_op(func_type func, logic signed [31:0] key);
      expected_rsp_type result;
      int  pos;
      bit  present;
      pos = 0;
      while (pos < model_keys.size() && model_keys[pos] < key)
         pos++;
      present = (pos < model_keys.size()) && (model_keys[pos] == key);
      result.status = ST_NOTFOUND;
      case (func)
         FUNC_INSERT: begin
            if (key == RESERVED_KEY || present) begin
               result.status = ST_DUP;
            end else if (model_keys.size() >= CAPACITY) begin
               result.status = ST_FULL;
            end else begin
               model_keys.insert(pos, key);
               result.status = ST_OK;
            end
         end
         FUNC_FIND: begin
            result.status = (key == RESERVED_KEY || present) ? ST_OK : ST_NOTFOUND;
         end
         FUNC_REMOVE: begin
            if (key == RESERVED_KEY) begin
               result.status = ST_RESERVED;
            end else if (present) begin
               model_keys.delete(pos);
               result.status = ST_OK;
            end
         end
         default: result.status = ST_NOTFOUND;
      endcase
      result.entry_count = 5'(model_keys.size());
      return result;
   endfunction

   // Send one request. A random idle burst may come first, unless the run is in its
   // quiet tail. The expectation is queued at the edge where the request is taken.
   task automatic send_request(func_type func, logic signed [31:0] key);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.key   <= key;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(predict_set_op(func, key));
   endtask

   // Lower valid once a group of requests is done.
   task automatic go_idle();
      req_ch.valid <= 1'b0;
   endtask

   // Hold off until every expected response has arrived.
   task automatic drain_responses();
      go_idle();
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // A random key, biased toward a narrow range so that hits and misses both occur.
   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(0, 9))
         0: return RESERVED_KEY;
         1: return 32'sh8000_0000;
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   function automatic func_type pick_func(int insert_weight);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_weight) return FUNC_INSERT;
      if (roll < insert_weight + (100 - insert_weight) / 2) return FUNC_FIND;
      if (roll < 98) return FUNC_REMOVE;
      return FUNC_NONE;
   endfunction

   // Response checker: compare each response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request waiting: status %0d count %0d",
                   rsp_ch.status, rsp_ch.entry_count);
            error_count++;
         end else begin
            expected_rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_ch.entry_count);
               error_count++;
            end
         end
      end
   end

   // Response side back-pressure comes in random bursts.
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_ch.ready <= 1'b1;
         sink_stall <= 0;
      end else if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_ch.ready <= (sink_stall == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         sink_stall <= $urandom_range(1, 8);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: the run must end long before this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Directed: field extremes, every operation and the reserved marker.
   task automatic test_edges();
      send_request(FUNC_FIND, 32'sh0000_0000);      // find in an empty set
      send_request(FUNC_REMOVE, 32'sh0000_0005);    // remove from an empty set
      send_request(FUNC_INSERT, 32'sh8000_0000);    // smallest key
      send_request(FUNC_INSERT, 32'sh7FFF_FFFE);    // largest storable key
      send_request(FUNC_INSERT, RESERVED_KEY);      // reserved marker reads as duplicate
      send_request(FUNC_FIND, RESERVED_KEY);        // reserved marker is always found
      send_request(FUNC_REMOVE, RESERVED_KEY);      // reserved marker cannot be removed
      send_request(FUNC_INSERT, 32'sh8000_0000);    // duplicate
      send_request(FUNC_FIND, 32'sh7FFF_FFFE);
      send_request(FUNC_NONE, 32'shFFFF_FFFF);      // unused code leaves the set alone
      send_request(FUNC_NONE, 32'sh0000_0000);
      send_request(FUNC_REMOVE, 32'sh8000_0000);
      send_request(FUNC_REMOVE, 32'sh7FFF_FFFE);
      send_request(FUNC_FIND, 32'sh8000_0000);      // gone again
      drain_responses();
   endtask

   // Directed: fill the set to capacity, then overflow it.
   task automatic test_full_set();
      for (int i = 0; i < CAPACITY; i++)
         send_request(FUNC_INSERT, (i % 2) ? -i * 1000 : i * 1000);
      send_request(FUNC_INSERT, 32'sh0000_0001);    // full set rejects a new key
      send_request(FUNC_INSERT, 32'sh0000_0000);    // present key still reports duplicate
      send_request(FUNC_FIND, -32'sd3000);
      drain_responses();
   endtask

   // Random mix. The insert weight swings so the set fills up and drains repeatedly.
   task automatic test_random_mix(int count);
      int weight;
      weight = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0)
            weight = $urandom_range(20, 80);
         if (i == count - 200)
            quiet_tail = 1'b1;
         send_request(pick_func(weight), pick_key());
      end
      go_idle();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_NONE;
      req_ch.key   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edges();
      test_full_set();
      test_random_mix(1800);

      // Wait for the last responses, then wait longer for any stray one.
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/sks_pkg.sv
hdl/sks_if.sv
hdl/sks_front.sv
hdl/sks_back.sv
hdl/sorted_key_set.sv
hdl/sks_checker.sv
bench/tb_sorted_key_set.sv
